// File: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the slot pool allocator checkers.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked in the same cycle, switched off while reset is held.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Implication checked in the next cycle, switched off while reset is held.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

// Implication checked in the next cycle, active during reset as well.
`define ASSERT_NEXT_ALWAYS(label, clk, ante, cons, msg) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/spa_pkg.sv
// ----------------------------------------------------------------------------
// Slot pool allocator package
// Request and response word types and the operation and status codes.
// ----------------------------------------------------------------------------
package spa_pkg;

    // Operation codes of a request word.
    typedef enum logic {
        OP_ALLOC = 1'b0,
        OP_FREE  = 1'b1
    } t_op;

    // Status codes of a response word.
    typedef enum logic [2:0] {
        ST_REUSED    = 3'd0,
        ST_NEW       = 3'd1,
        ST_EXHAUSTED = 3'd2,
        ST_BADCOUNT  = 3'd3,
        ST_FREED     = 3'd4,
        ST_EXTERNAL  = 3'd5,
        ST_IGNORED   = 3'd6,
        ST_FULL      = 3'd7
    } t_status;

    // Request word.
    typedef struct packed {
        t_op         op;
        logic [7:0]  count;
        logic [15:0] handle;
        logic        handle_null;
    } t_req;

    // Response word.
    typedef struct packed {
        t_status    status;
        logic [3:0] slot;
    } t_rsp;

endpackage

// File: rtl/spa_stream_if.sv
// ----------------------------------------------------------------------------
// Valid/ready stream interface
// Carries one word per handshake between a source and a sink.
// ----------------------------------------------------------------------------
interface spa_stream_if #(
    parameter type t_payload = logic
);
    logic     valid;
    logic     ready;
    t_payload data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// File: rtl/slot_pool_allocator.sv
// ----------------------------------------------------------------------------
// Slot pool allocator
// Hands out slots of a fixed pool from a free stack or a bump counter and
// takes freed slots back onto the stack.
// ----------------------------------------------------------------------------
//  Channel   Direction  Word    Fields
//  i_req     in         t_req   op, count, handle, handle_null
//  o_rsp     out        t_rsp   status, slot
//
// One word is accepted every cycle while i_req.ready is high. Its response
// waits in stage one behind the registered read of the stack RAM and is then
// loaded into the output register, from which it can be taken.
// The stack depth and the bump counter are updated at acceptance, so the next
// word sees them at once. Reset clears both counters and the valid flags; the
// stack RAM needs no clearing pass, since only entries below the depth are read.
// A stalled output holds its word; i_req stalls only once stage one holds a
// word as well, and then follows o_rsp.ready in the same cycle.
module slot_pool_allocator
    import spa_pkg::*;
#(
    parameter int POOL_SLOTS = 16
) (
    input  logic i_clk,
    input  logic i_rst_n,
    spa_stream_if.sink   i_req,
    spa_stream_if.source o_rsp
);

    localparam int IW = $clog2(POOL_SLOTS);
    localparam int DW = $clog2(POOL_SLOTS + 1);
    localparam logic [DW-1:0] SLOTS_D = DW'(POOL_SLOTS);
    localparam logic [15:0]   SLOTS_H = 16'(POOL_SLOTS);

    // Low four bits of a slot index.
    function automatic logic [3:0] f_slot4(input logic [IW-1:0] idx);
        logic [IW+3:0] w;
        w = (IW + 4)'(idx);
        return w[3:0];
    endfunction

    logic [DW-1:0] r_depth, n_depth;
    logic [DW-1:0] r_fresh, n_fresh;

    logic          r_s1_valid;
    t_status       r_s1_status;
    logic [3:0]    r_s1_slot;
    logic          r_s1_pop;

    logic          r_out_valid;
    t_rsp          r_out;

    t_status       dec_status;
    logic [3:0]    dec_slot;
    logic          dec_pop;
    logic          dec_push;
    logic          advance;
    logic          accept;
    logic [IW-1:0] ram_rdata;
    logic [DW-1:0] top_addr;

    // Handshake: stage one moves on when the output register is free.
    assign advance     = !r_out_valid || o_rsp.ready;
    assign i_req.ready = !r_s1_valid || advance;
    assign accept      = i_req.valid && i_req.ready;
    assign top_addr    = r_depth - DW'(1);

    // Request decode against the current stack depth and bump counter.
    always_comb begin
        n_depth    = r_depth;
        n_fresh    = r_fresh;
        dec_status = ST_IGNORED;
        dec_slot   = 4'd0;
        dec_pop    = 1'b0;
        dec_push   = 1'b0;
        if (i_req.data.op == OP_ALLOC) begin
            if (i_req.data.count != 8'd1) begin
                dec_status = ST_BADCOUNT;
            end else if (r_depth != '0) begin
                dec_status = ST_REUSED;
                dec_pop    = 1'b1;
                n_depth    = r_depth - DW'(1);
            end else if (r_fresh != SLOTS_D) begin
                dec_status = ST_NEW;
                dec_slot   = f_slot4(r_fresh[IW-1:0]);
                n_fresh    = r_fresh + DW'(1);
            end else begin
                dec_status = ST_EXHAUSTED;
            end
        end else begin
            if (i_req.data.handle_null || i_req.data.count == 8'd0) begin
                dec_status = ST_IGNORED;
            end else if (i_req.data.handle >= SLOTS_H) begin
                dec_status = ST_EXTERNAL;
            end else if (r_depth == SLOTS_D) begin
                dec_status = ST_FULL;
            end else begin
                dec_status = ST_FREED;
                dec_push   = 1'b1;
                n_depth    = r_depth + DW'(1);
            end
        end
    end

    // Free stack storage: push writes at the depth, pop reads the top entry.
    spa_ram #(
        .WIDTH (IW),
        .DEPTH (POOL_SLOTS)
    ) u_stack (
        .i_clk   (i_clk),
        .i_we    (accept && dec_push),
        .i_waddr (r_depth[IW-1:0]),
        .i_wdata (i_req.data.handle[IW-1:0]),
        .i_re    (accept && dec_pop),
        .i_raddr (top_addr[IW-1:0]),
        .o_rdata (ram_rdata)
    );

    // Stack depth and bump counter.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_depth <= '0;
            r_fresh <= '0;
        end else if (accept) begin
            r_depth <= n_depth;
            r_fresh <= n_fresh;
        end
    end

    // Stage one: decoded status waiting for the stack read data.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (i_req.ready) begin
            r_s1_valid <= i_req.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_status <= dec_status;
            r_s1_slot   <= dec_slot;
            r_s1_pop    <= dec_pop;
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && r_s1_valid) begin
            r_out.status <= r_s1_status;
            r_out.slot   <= r_s1_pop ? f_slot4(ram_rdata) : r_s1_slot;
        end
    end

    assign o_rsp.valid = r_out_valid;
    assign o_rsp.data  = r_out;

endmodule

// File: rtl/spa_ram.sv
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module spa_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port; the data holds while no read is issued.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/spa_checker.sv
// ----------------------------------------------------------------------------
// Slot pool allocator checker
// Port-level assertions on the request and response channels.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module spa_checker
    import spa_pkg::*;
(
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_req_valid,
    input logic       i_req_ready,
    input logic       i_rsp_valid,
    input logic       i_rsp_ready,
    input t_status    i_rsp_status,
    input logic [3:0] i_rsp_slot
);

    // A slot number is only granted by a successful allocate.
    `ASSERT_IMPLY(a_slot_zero, i_clk, i_rst_n,
        i_rsp_valid && i_rsp_status != ST_REUSED && i_rsp_status != ST_NEW,
        i_rsp_slot == 4'd0, "slot is not zero for a non-granting status")

    // The request side only stalls behind a stalled response register.
    `ASSERT_IMPLY(a_backpressure, i_clk, i_rst_n,
        !i_req_ready, i_rsp_valid && !i_rsp_ready,
        "request stalled while the response side is free")

    // A response word waits until it is taken.
    `ASSERT_NEXT(a_rsp_hold, i_clk, i_rst_n,
        i_rsp_valid && !i_rsp_ready, i_rsp_valid,
        "response word withdrawn before it was taken")

    // Reset empties the pipeline.
    `ASSERT_NEXT_ALWAYS(a_reset_empty, i_clk,
        !i_rst_n, !i_rsp_valid, "response valid after reset")

endmodule

bind slot_pool_allocator spa_checker u_spa_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_req_valid  (i_req.valid),
    .i_req_ready  (i_req.ready),
    .i_rsp_valid  (o_rsp.valid),
    .i_rsp_ready  (o_rsp.ready),
    .i_rsp_status (o_rsp.data.status),
    .i_rsp_slot   (o_rsp.data.slot)
);
